// File: rtl/pcrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrr_pkg: shared types and constants of the per-class round-robin scheduler
// Operation and status codes, default sizes and the command word that travels
// from the front end to the back end.
// ----------------------------------------------------------------------------
package pcrr_pkg;

  // default sizes
  localparam int DEF_MAX_CLASSES = 16;
  localparam int DEF_QUEUE_DEPTH = 64;

  // field widths
  localparam int HANDLE_W = 16;
  localparam int CLASS_W  = 4;
  localparam int CFG_W    = 5;
  localparam int STATUS_W = 3;
  localparam int PEND_W   = 11;
  // class index and class count wide enough for the largest class count
  localparam int CIDX_W   = 6;
  localparam int NCLS_W   = 7;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_ENQ      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DEQ      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADCLASS = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

  // classified command word
  typedef struct packed {
    logic                op;
    logic                bad;
    logic [CIDX_W-1:0]   cls;
    logic [HANDLE_W-1:0] handle;
    logic [NCLS_W-1:0]   ncls;
  } cmd_t;

endpackage

// File: rtl/pcrr_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrr_ifs: channel interfaces of the scheduler
// Request, response and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface pcrr_req_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [pcrr_pkg::CLASS_W-1:0]  pkt_class;
  logic [pcrr_pkg::HANDLE_W-1:0] pkt_handle;

  modport source (output valid, op, pkt_class, pkt_handle, input ready);
  modport sink (input valid, op, pkt_class, pkt_handle, output ready);
endinterface

interface pcrr_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pcrr_pkg::STATUS_W-1:0] status;
  logic [pcrr_pkg::HANDLE_W-1:0] out_handle;
  logic [pcrr_pkg::CLASS_W-1:0]  out_class;
  logic [pcrr_pkg::PEND_W-1:0]   pending;
  logic                          active;

  modport source (output valid, status, out_handle, out_class, pending, active,
                  input ready);
  modport sink (input valid, status, out_handle, out_class, pending, active,
                output ready);
endinterface

interface pcrr_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [pcrr_pkg::CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: rtl/per_class_round_robin_scheduler.sv
`timescale 1ns / 1ps
// Results: an enqueue answers as the back end pops it, a dequeue after the
//   registered handle memory read. Throughput: enqueues at 1 word per cycle
//   while the receiver keeps up; no command is taken during a dequeue's read.
// Reset (rst, synchronous): all class FIFOs empty, round-robin pointer and
//   packet total zero, class count 16; handle memory is not cleared.
// ----------------------------------------------------------------------------
// per_class_round_robin_scheduler: per-class round-robin packet scheduler
// Front end classifies request words into a short queue; the back end keeps
// one FIFO of packet handles per class and serves classes in turn.
// ----------------------------------------------------------------------------
module per_class_round_robin_scheduler #(
  parameter int MAX_CLASSES = pcrr_pkg::DEF_MAX_CLASSES,
  parameter int QUEUE_DEPTH = pcrr_pkg::DEF_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  pcrr_req_if.sink   req,
  pcrr_rsp_if.source rsp,
  pcrr_cfg_if.sink   cfg
);
  pcrr_pkg::cmd_t front_cmd;
  pcrr_pkg::cmd_t back_cmd;
  logic           push;
  logic           full;
  logic           pop;
  logic           cmd_valid;

  // request classification and class count register
  pcrr_front #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cfg  (cfg),
    .push (push),
    .cmd  (front_cmd),
    .full (full)
  );

  // command queue between the two halves
  pcrr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_cmd),
    .full  (full),
    .pop   (pop),
    .valid (cmd_valid),
    .dout  (back_cmd)
  );

  // scheduling back end
  pcrr_back #(
    .MAX_CLASSES (MAX_CLASSES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (back_cmd),
    .cmd_pop   (pop),
    .rsp       (rsp)
  );
endmodule

// File: rtl/pcrr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrr_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pcrr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [ADDR_W-1:0]        rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// File: rtl/pcrr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrr_front: request front end
// Holds the class count register, accepts request words, clamps the class
// count and flags out-of-range enqueue classes before queueing the command.
// ----------------------------------------------------------------------------
module pcrr_front #(
  parameter int MAX_CLASSES = pcrr_pkg::DEF_MAX_CLASSES
) (
  input  logic           clk,
  input  logic           rst,
  pcrr_req_if.sink       req,
  pcrr_cfg_if.sink       cfg,
  output logic           push,
  output pcrr_pkg::cmd_t cmd,
  input  logic           full
);
  logic [pcrr_pkg::CFG_W-1:0]  num_classes;
  logic [pcrr_pkg::NCLS_W-1:0] ncls;

  // class count register, writable at any time
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      num_classes <= pcrr_pkg::CFG_RESET;
    end else if (cfg.valid) begin
      num_classes <= cfg.data;
    end
  end

  // effective class count: zero acts as one, clamp at the class limit
  always_comb begin
    if (num_classes == '0) begin
      ncls = pcrr_pkg::NCLS_W'(1);
    end else if (int'(num_classes) > MAX_CLASSES) begin
      ncls = pcrr_pkg::NCLS_W'(MAX_CLASSES);
    end else begin
      ncls = pcrr_pkg::NCLS_W'(num_classes);
    end
  end

  // classify and queue
  assign req.ready  = !full;
  assign push       = req.valid && !full;
  assign cmd.op     = req.op;
  assign cmd.bad    = (req.op == pcrr_pkg::OP_ENQ) &&
                      (pcrr_pkg::NCLS_W'(req.pkt_class) >= ncls);
  assign cmd.cls    = pcrr_pkg::CIDX_W'(req.pkt_class);
  assign cmd.handle = req.pkt_handle;
  assign cmd.ncls   = ncls;
endmodule

// File: rtl/pcrr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrr_queue: two-entry command queue
// Decouples the front end from the back end so each can stall on its own.
// ----------------------------------------------------------------------------
module pcrr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pcrr_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output pcrr_pkg::cmd_t dout
);
  pcrr_pkg::cmd_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign dout  = slot[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end
endmodule

// File: rtl/pcrr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrr_back: scheduling back end
// Owns the per-class FIFO pointers and counts, the handle memory, the
// round-robin pointer and the response register. An enqueue loads its
// response as its command is popped; a dequeue finds its class with a
// rotating priority search and waits in S_WAIT for the registered memory read.
// ----------------------------------------------------------------------------
module pcrr_back #(
  parameter int MAX_CLASSES = pcrr_pkg::DEF_MAX_CLASSES,
  parameter int QUEUE_DEPTH = pcrr_pkg::DEF_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  pcrr_pkg::cmd_t cmd,
  output logic           cmd_pop,
  pcrr_rsp_if.source     rsp
);
  localparam int CLS_W  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOTS  = MAX_CLASSES * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int TOT_W  = $clog2(SLOTS + 1);

  typedef enum logic {S_IDLE, S_WAIT} state_t;

  state_t                       state;
  logic [CNT_W-1:0]             counts [MAX_CLASSES];
  logic [PTR_W-1:0]             heads  [MAX_CLASSES];
  logic [PTR_W-1:0]             tails  [MAX_CLASSES];
  logic [CLS_W-1:0]             rr;
  logic [TOT_W-1:0]             total;
  logic [TOT_W-1:0]             total_next;
  logic [pcrr_pkg::CLASS_W-1:0] hold_class;

  logic [MAX_CLASSES-1:0]       busy;
  logic [CLS_W-1:0]             start;
  logic                         hi_hit;
  logic                         lo_hit;
  logic [CLS_W-1:0]             hi_idx;
  logic [CLS_W-1:0]             lo_idx;
  logic                         found;
  logic [CLS_W-1:0]             sel;
  logic [CLS_W-1:0]             rr_next;
  logic [CLS_W-1:0]             idx;
  logic [CNT_W-1:0]             cnt_sel;
  logic [PTR_W-1:0]             ptr_sel;
  logic [PTR_W-1:0]             ptr_inc;
  logic                         out_free;
  logic                         do_enq;
  logic                         do_deq;
  logic                         rsp_load;
  logic [ADDR_W-1:0]            addr;
  logic [pcrr_pkg::HANDLE_W-1:0] rd_data;
  logic [31:0]                  total32;

  // rotating priority search over non-empty classes in use
  always_comb begin
    for (int c = 0; c < MAX_CLASSES; c++) begin
      busy[c] = (counts[c] != '0) && (pcrr_pkg::NCLS_W'(c) < cmd.ncls);
    end
    start  = (pcrr_pkg::NCLS_W'(rr) >= cmd.ncls) ? '0 : rr;
    hi_hit = 1'b0;
    lo_hit = 1'b0;
    hi_idx = '0;
    lo_idx = '0;
    for (int c = MAX_CLASSES - 1; c >= 0; c--) begin
      if (busy[c]) begin
        lo_hit = 1'b1;
        lo_idx = CLS_W'(c);
        if (CLS_W'(c) >= start) begin
          hi_hit = 1'b1;
          hi_idx = CLS_W'(c);
        end
      end
    end
    found   = hi_hit || lo_hit;
    sel     = hi_hit ? hi_idx : lo_idx;
    rr_next = ((32'(sel) + 32'd1) >= 32'(cmd.ncls)) ? '0 : CLS_W'(32'(sel) + 32'd1);
  end

  // selected class: search result for dequeue, request class for enqueue
  always_comb begin
    idx     = (cmd.op == pcrr_pkg::OP_DEQ) ? sel : cmd.cls[CLS_W-1:0];
    cnt_sel = counts[idx];
    ptr_sel = (cmd.op == pcrr_pkg::OP_DEQ) ? heads[idx] : tails[idx];
    ptr_inc = (32'(ptr_sel) == 32'(QUEUE_DEPTH - 1)) ? '0 : ptr_sel + PTR_W'(1);
    addr    = ADDR_W'(32'(idx) * 32'(QUEUE_DEPTH) + 32'(ptr_sel));
  end

  // issue decisions
  assign out_free = !rsp.valid || rsp.ready;
  assign cmd_pop  = (state == S_IDLE) && cmd_valid && out_free;
  assign do_enq   = cmd_pop && (cmd.op == pcrr_pkg::OP_ENQ) && !cmd.bad &&
                    (32'(cnt_sel) < 32'(QUEUE_DEPTH));
  assign do_deq   = cmd_pop && (cmd.op == pcrr_pkg::OP_DEQ) && found;
  // a response word is loaded now or after the memory wait
  assign rsp_load = (cmd_pop && !do_deq) || ((state == S_WAIT) && out_free);

  always_comb begin
    total_next = total;
    if (do_enq) begin
      total_next = total + TOT_W'(1);
    end else if (do_deq) begin
      total_next = total - TOT_W'(1);
    end
  end
  assign total32 = 32'(total_next);

  // handle memory
  pcrr_ram #(
    .WIDTH (pcrr_pkg::HANDLE_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (do_enq),
    .wr_addr (addr),
    .wr_data (cmd.handle),
    .rd_en   (do_deq),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  // sequencer, class state and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rr        <= '0;
      total     <= '0;
      rsp.valid <= 1'b0;
      for (int c = 0; c < MAX_CLASSES; c++) begin
        counts[c] <= '0;
        heads[c]  <= '0;
        tails[c]  <= '0;
      end
    end else begin
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      total <= total_next;
      if (do_enq) begin
        counts[idx] <= cnt_sel + CNT_W'(1);
        tails[idx]  <= ptr_inc;
      end
      if (do_deq) begin
        counts[idx] <= cnt_sel - CNT_W'(1);
        heads[idx]  <= ptr_inc;
        rr          <= rr_next;
      end
      case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            rsp.pending    <= total32[pcrr_pkg::PEND_W-1:0];
            rsp.active     <= (total_next != '0);
            rsp.out_handle <= '0;
            rsp.out_class  <= '0;
            if (do_deq) begin
              hold_class <= pcrr_pkg::CLASS_W'(32'(sel));
              state      <= S_WAIT;
            end else begin
              if (cmd.op == pcrr_pkg::OP_DEQ) begin
                rsp.status <= pcrr_pkg::ST_EMPTY;
              end else if (cmd.bad) begin
                rsp.status <= pcrr_pkg::ST_BADCLASS;
              end else if (do_enq) begin
                rsp.status <= pcrr_pkg::ST_ENQ;
              end else begin
                rsp.status <= pcrr_pkg::ST_FULL;
              end
            end
          end
        end
        S_WAIT: begin
          if (out_free) begin
            rsp.status     <= pcrr_pkg::ST_DEQ;
            rsp.out_handle <= rd_data;
            rsp.out_class  <= hold_class;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // a dequeued handle is only presented from the memory wait step
  a_deq_from_wait: assert property (@(posedge clk) disable iff (rst)
    ($rose(rsp.valid) && rsp.status == pcrr_pkg::ST_DEQ) |-> $past(state) == S_WAIT)
    else $error("dequeue response without memory wait");

  // no command is taken while a memory read is outstanding
  a_no_pop_in_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |-> !cmd_pop)
    else $error("command popped during memory wait");

  // the served class is inside the class count in use
  a_sel_in_range: assert property (@(posedge clk) disable iff (rst)
    do_deq |-> (pcrr_pkg::NCLS_W'(sel) < cmd.ncls))
    else $error("served class beyond class count");

  // the packet total never goes past the storage size
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    32'(total) <= 32'(SLOTS))
    else $error("packet total exceeds storage");

  // after a reset no response is pending
  a_reset_clear: assert property (@(posedge clk) rst |=> !rsp.valid)
    else $error("response valid after reset");
`endif
endmodule

// File: bench/per_class_round_robin_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_class_round_robin_scheduler_tb: self-checking bench of the scheduler
// A directed table covers the empty, bad-class, full and stranded-class cases
// and the class-count limits. Random enqueue, dequeue, fill and noise
// sequences then run under several class counts, with bursty requests and a
// stalling receiver. Every response word is checked against its table entry
// or a behavioral model of the per-class FIFOs and the rotating pointer.
// ----------------------------------------------------------------------------
module per_class_round_robin_scheduler_tb;
  import pcrr_pkg::*;

  localparam int MAX_CLS         = DEF_MAX_CLASSES;
  localparam int DEPTH           = DEF_QUEUE_DEPTH;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_CYCLES     = 500;
  localparam int DRAIN_CYCLES    = 16;
  localparam int NUM_PHASES      = 9;
  localparam int ITEMS_PER_PHASE = 165;
  localparam int NUM_DIR         = 33;

  // one response word
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] out_handle;
    logic [CLASS_W-1:0]  out_class;
    logic [PEND_W-1:0]   pending;
    logic                active;
  } sched_result_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;
  typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_EVERY3} rx_mode_e;
  typedef enum int {SEQ_ENQ, SEQ_DEQ, SEQ_FILL, SEQ_NOISE} seq_kind_e;

  // directed row: a request word repeated reps times, or a class-count write
  typedef struct packed {
    row_kind_e           kind;
    logic                op;
    logic [CLASS_W-1:0]  cls;
    logic [HANDLE_W-1:0] handle;
    logic [CFG_W-1:0]    cfgv;
    logic [6:0]          reps;
    logic                fixed;
    sched_result_t       res;
  } dir_row_t;

  localparam sched_result_t NO_RES = '0;

  localparam dir_row_t DIR_TAB [NUM_DIR] = '{
    // empty after reset, then two classes at the extremes
    '{ROW_WORD, OP_DEQ, 4'd0, 16'h0000, 5'd0, 7'd1, 1'b1,
      '{ST_EMPTY, 16'h0000, 4'd0, 11'd0, 1'b0}},
    '{ROW_WORD, OP_ENQ, 4'd0, 16'hFFFF, 5'd0, 7'd1, 1'b1,
      '{ST_ENQ, 16'h0000, 4'd0, 11'd1, 1'b1}},
    '{ROW_WORD, OP_ENQ, 4'd15, 16'h0000, 5'd0, 7'd1, 1'b1,
      '{ST_ENQ, 16'h0000, 4'd0, 11'd2, 1'b1}},
    '{ROW_WORD, OP_ENQ, 4'd15, 16'hA5A5, 5'd0, 7'd1, 1'b1,
      '{ST_ENQ, 16'h0000, 4'd0, 11'd3, 1'b1}},
    '{ROW_WORD, OP_DEQ, 4'd0, 16'h0000, 5'd0, 7'd1, 1'b1,
      '{ST_DEQ, 16'hFFFF, 4'd0, 11'd2, 1'b1}},
    '{ROW_WORD, OP_DEQ, 4'd0, 16'h0000, 5'd0, 7'd1, 1'b1,
      '{ST_DEQ, 16'h0000, 4'd15, 11'd1, 1'b1}},
    '{ROW_WORD, OP_DEQ, 4'd0, 16'h0000, 5'd0, 7'd1, 1'b1,
      '{ST_DEQ, 16'hA5A5, 4'd15, 11'd0, 1'b0}},
    '{ROW_WORD, OP_DEQ, 4'd0, 16'h0000, 5'd0, 7'd1, 1'b1,
      '{ST_EMPTY, 16'h0000, 4'd0, 11'd0, 1'b0}},
    // four classes: bad class at the boundary and at the top
    '{ROW_CFG, OP_ENQ, 4'd0, 16'h0000, 5'd4, 7'd1, 1'b0, NO_RES},
    '{ROW_WORD, OP_ENQ, 4'd4, 16'hBEEF, 5'd0, 7'd1, 1'b1,
      '{ST_BADCLASS, 16'h0000, 4'd0, 11'd0, 1'b0}},
    '{ROW_WORD, OP_ENQ, 4'd15, 16'hFFFF, 5'd0, 7'd1, 1'b1,
      '{ST_BADCLASS, 16'h0000, 4'd0, 11'd0, 1'b0}},
    '{ROW_WORD, OP_ENQ, 4'd3, 16'h1234, 5'd0, 7'd1, 1'b0, NO_RES},
    '{ROW_WORD, OP_ENQ, 4'd1, 16'h5555, 5'd0, 7'd1, 1'b0, NO_RES},
    // zero class count acts as one; classes 1 and 3 are stranded
    '{ROW_CFG, OP_ENQ, 4'd0, 16'h0000, 5'd0, 7'd1, 1'b0, NO_RES},
    '{ROW_WORD, OP_ENQ, 4'd1, 16'h7777, 5'd0, 7'd1, 1'b0, NO_RES},
    '{ROW_WORD, OP_ENQ, 4'd0, 16'h8001, 5'd0, 7'd1, 1'b0, NO_RES},
    '{ROW_WORD, OP_DEQ, 4'd0, 16'h0000, 5'd0, 7'd1, 1'b0, NO_RES},
    '{ROW_WORD, OP_DEQ, 4'd0, 16'h0000, 5'd0, 7'd1, 1'b0, NO_RES},
    // oversized class count acts as the maximum; stranded words come back
    '{ROW_CFG, OP_ENQ, 4'd0, 16'h0000, 5'd31, 7'd1, 1'b0, NO_RES},
    '{ROW_WORD, OP_DEQ, 4'd0, 16'h0000, 5'd0, 7'd1, 1'b0, NO_RES},
    '{ROW_WORD, OP_DEQ, 4'd0, 16'h0000, 5'd0, 7'd1, 1'b0, NO_RES},
    // park the pointer high, then shrink the class count below it
    '{ROW_WORD, OP_ENQ, 4'd9, 16'h0F0F, 5'd0, 7'd1, 1'b0, NO_RES},
    '{ROW_WORD, OP_ENQ, 4'd2, 16'h2222, 5'd0, 7'd1, 1'b0, NO_RES},
    '{ROW_WORD, OP_DEQ, 4'd0, 16'h0000, 5'd0, 7'd1, 1'b0, NO_RES},
    '{ROW_CFG, OP_ENQ, 4'd0, 16'h0000, 5'd4, 7'd1, 1'b0, NO_RES},
    '{ROW_WORD, OP_DEQ, 4'd0, 16'h0000, 5'd0, 7'd1, 1'b0, NO_RES},
    // fill one class, overflow it, strand it, release it
    '{ROW_CFG, OP_ENQ, 4'd0, 16'h0000, 5'd16, 7'd1, 1'b0, NO_RES},
    '{ROW_WORD, OP_ENQ, 4'd5, 16'hC000, 5'd0, 7'd64, 1'b0, NO_RES},
    '{ROW_WORD, OP_ENQ, 4'd5, 16'hFFFE, 5'd0, 7'd1, 1'b0, NO_RES},
    '{ROW_CFG, OP_ENQ, 4'd0, 16'h0000, 5'd2, 7'd1, 1'b0, NO_RES},
    '{ROW_WORD, OP_DEQ, 4'd0, 16'h0000, 5'd0, 7'd1, 1'b0, NO_RES},
    '{ROW_CFG, OP_ENQ, 4'd0, 16'h0000, 5'd16, 7'd1, 1'b0, NO_RES},
    '{ROW_WORD, OP_DEQ, 4'd0, 16'h0000, 5'd0, 7'd1, 1'b0, NO_RES}
  };

  // class counts of the random phases; -1 picks one at random
  localparam int PHASE_CFG [NUM_PHASES] = '{16, 1, 0, 31, 8, -1, 3, -1, 16};

  logic clk = 1'b0;
  logic rst;

  pcrr_req_if req_ch ();
  pcrr_rsp_if rsp_ch ();
  pcrr_cfg_if cfg_ch ();

  per_class_round_robin_scheduler dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scheduler model state
  logic [HANDLE_W-1:0] fifo_mem [MAX_CLS][DEPTH];
  logic [5:0]          fifo_head [MAX_CLS];
  logic [5:0]          fifo_tail [MAX_CLS];
  logic [6:0]          fifo_cnt [MAX_CLS];
  logic [3:0]          rr_ptr;
  logic [PEND_W-1:0]   total_cnt;
  logic [CFG_W-1:0]    ncls_cfg;

  sched_result_t sched_due [$];
  int            mismatch_cnt = 0;
  int            cycle_cnt = 0;
  int            burst_left = 0;
  bit            gappy = 1'b1;
  logic          hold_go;

  function automatic int eff_classes();
    if (ncls_cfg == 0) return 1;
    if (ncls_cfg > MAX_CLS) return MAX_CLS;
    return int'(ncls_cfg);
  endfunction

  // advance the model by one request word and return its response
  function automatic sched_result_t schedule_word(input logic op,
                                                  input logic [CLASS_W-1:0] cls,
                                                  input logic [HANDLE_W-1:0] hnd);
    sched_result_t r;
    int            n;
    int            p;
    int            i;
    bit            found;
    r = '0;
    n = eff_classes();
    if (op == OP_ENQ) begin
      if (cls >= n) begin
        r.status = ST_BADCLASS;
      end else if (fifo_cnt[cls] >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        fifo_mem[cls][fifo_tail[cls]] = hnd;
        // 6-bit pointer wraps at the queue depth
        fifo_tail[cls] = fifo_tail[cls] + 6'd1;
        fifo_cnt[cls]  = fifo_cnt[cls] + 7'd1;
        total_cnt      = total_cnt + 11'd1;
        r.status       = ST_ENQ;
      end
    end else begin
      // pointer past a shrunk class count restarts at class 0
      p = (rr_ptr >= n) ? 0 : int'(rr_ptr);
      found = 1'b0;
      for (i = 0; i < n && !found; i++) begin
        if (fifo_cnt[p] != 0) found = 1'b1;
        else p = (p + 1 >= n) ? 0 : p + 1;
      end
      if (found) begin
        r.out_handle = fifo_mem[p][fifo_head[p]];
        r.out_class  = CLASS_W'(p);
        fifo_head[p] = fifo_head[p] + 6'd1;
        fifo_cnt[p]  = fifo_cnt[p] - 7'd1;
        total_cnt    = total_cnt - 11'd1;
        rr_ptr       = 4'((p + 1 >= n) ? 0 : p + 1);
        r.status     = ST_DEQ;
      end else begin
        r.status = ST_EMPTY;
      end
    end
    r.pending = total_cnt;
    r.active  = (total_cnt != 0);
    return r;
  endfunction

  function automatic logic [HANDLE_W-1:0] rand_handle();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return 16'h0000;
    if (sel == 1) return 16'hFFFF;
    return HANDLE_W'($urandom_range(0, 65535));
  endfunction

  // offer one request word in bursts; queue its response once accepted
  task automatic send_word(input logic op, input logic [CLASS_W-1:0] cls,
                           input logic [HANDLE_W-1:0] hnd, input bit fixed,
                           input sched_result_t fixed_res);
    sched_result_t r;
    int            gap;
    if (burst_left <= 0) begin
      if (gappy) begin
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          req_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left = $urandom_range(1, 24);
    end
    req_ch.valid      <= 1'b1;
    req_ch.op         <= op;
    req_ch.pkt_class  <= cls;
    req_ch.pkt_handle <= hnd;
    do @(posedge clk); while (!req_ch.ready);
    r = schedule_word(op, cls, hnd);
    sched_due.insert(sched_due.size(), fixed ? fixed_res : r);
    burst_left--;
  endtask

  // class-count write, only with the scheduler drained
  task automatic write_classes(input logic [CFG_W-1:0] v);
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sched_due.size() != 0);
    repeat (4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    ncls_cfg = v;
  endtask

  task automatic report_mismatch(input string why, input sched_result_t want,
                                 input sched_result_t got);
    if (mismatch_cnt < 10) begin
      $display("%s: want st=%0d h=%h c=%0d pend=%0d act=%0d", why, want.status,
               want.out_handle, want.out_class, want.pending, want.active);
      $display("  got st=%0d h=%h c=%0d pend=%0d act=%0d", got.status,
               got.out_handle, got.out_class, got.pending, got.active);
    end
    mismatch_cnt++;
  endtask

  // stimulus: directed table, then random phases
  initial begin
    int        ph;
    int        r;
    int        k;
    int        n;
    int        len;
    int        left;
    int        choice;
    int        c;
    seq_kind_e seq;
    logic      op;
    logic [CLASS_W-1:0] cls;

    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.op         <= OP_ENQ;
    req_ch.pkt_class  <= '0;
    req_ch.pkt_handle <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.data       <= '0;
    hold_go           <= 1'b0;

    for (k = 0; k < MAX_CLS; k++) begin
      fifo_head[k] = '0;
      fifo_tail[k] = '0;
      fifo_cnt[k]  = '0;
    end
    rr_ptr    = '0;
    total_cnt = '0;
    ncls_cfg  = CFG_RESET;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < NUM_DIR; r++) begin
      if (DIR_TAB[r].kind == ROW_CFG) begin
        write_classes(DIR_TAB[r].cfgv);
      end else begin
        for (k = 0; k < DIR_TAB[r].reps; k++)
          send_word(DIR_TAB[r].op, DIR_TAB[r].cls,
                    DIR_TAB[r].handle + HANDLE_W'(k), DIR_TAB[r].fixed,
                    DIR_TAB[r].res);
      end
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (PHASE_CFG[ph] < 0) write_classes(CFG_W'($urandom_range(0, 31)));
      else write_classes(CFG_W'(PHASE_CFG[ph]));
      gappy = ($urandom_range(0, 3) != 0);
      // long receiver hold-off early in the random part
      if (ph == 0) hold_go <= 1'b1;
      n = eff_classes();
      left = ITEMS_PER_PHASE;
      while (left > 0) begin
        choice = $urandom_range(0, 99);
        if (choice < 35) begin
          seq = SEQ_ENQ;
          len = $urandom_range(1, 12);
        end else if (choice < 65) begin
          seq = SEQ_DEQ;
          len = $urandom_range(1, 12);
        end else if (choice < 72) begin
          seq = SEQ_FILL;
          len = DEPTH + 2;
        end else if (choice < 80) begin
          seq = SEQ_DEQ;
          len = $urandom_range(20, 70);
        end else begin
          seq = SEQ_NOISE;
          len = $urandom_range(1, 6);
        end
        c = $urandom_range(0, n - 1);
        for (k = 0; k < len; k++) begin
          case (seq)
            SEQ_ENQ: begin
              op  = OP_ENQ;
              cls = CLASS_W'($urandom_range(0, n - 1));
            end
            SEQ_DEQ: begin
              op  = OP_DEQ;
              cls = CLASS_W'($urandom_range(0, 15));
            end
            SEQ_FILL: begin
              op  = OP_ENQ;
              cls = CLASS_W'(c);
            end
            default: begin
              op  = logic'($urandom_range(0, 1));
              cls = CLASS_W'($urandom_range(0, 15));
            end
          endcase
          send_word(op, cls, rand_handle(), 1'b0, NO_RES);
        end
        left -= len;
      end
    end

    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sched_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && sched_due.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // receiver: one long hold-off on request, otherwise changing stall modes
  initial begin
    rx_mode_e mode;
    int       mode_left;
    int       tick;
    bit       held;
    rsp_ch.ready <= 1'b0;
    mode      = RX_OPEN;
    mode_left = 0;
    tick      = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !held) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        tick++;
        case (mode)
          RX_OPEN:   rsp_ch.ready <= 1'b1;
          RX_HALF:   rsp_ch.ready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   rsp_ch.ready <= (tick % 3 == 0);
        endcase
      end
    end
  end

  // response check against the oldest expected word
  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.status     = rsp_ch.status;
      got.out_handle = rsp_ch.out_handle;
      got.out_class  = rsp_ch.out_class;
      got.pending    = rsp_ch.pending;
      got.active     = rsp_ch.active;
      if (sched_due.size() == 0) begin
        report_mismatch("unexpected response word", NO_RES, got);
      end else begin
        want = sched_due.pop_front();
        if (got.status !== want.status || got.out_handle !== want.out_handle ||
            got.out_class !== want.out_class || got.pending !== want.pending ||
            got.active !== want.active)
          report_mismatch("response mismatch", want, got);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

// File: per_class_round_robin_scheduler.f
rtl/pcrr_pkg.sv
rtl/pcrr_ifs.sv
rtl/pcrr_ram.sv
rtl/pcrr_front.sv
rtl/pcrr_queue.sv
rtl/pcrr_back.sv
rtl/per_class_round_robin_scheduler.sv
bench/per_class_round_robin_scheduler_tb.sv
